[rtl/core/assert_macros.svh]
// Assertion helpers; they compile to nothing when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check prop on every rising edge of clk while rst_n is high.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same check on the usual clock and reset.
`define ASSERT_CHK(lbl, prop) `ASSERT_AT(lbl, clk_i, rst_ni, prop)

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_CHK(lbl, prop)

`endif

`endif

[rtl/core/pnm_pkg.sv]
`default_nettype none

package pnm_pkg;

  localparam int unsigned DIM_BITS_DEF = 16;
  localparam int unsigned MAXVAL_OK    = 255;

  // result queue
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RQ_PTR_W  = $clog2(RES_DEPTH);
  localparam int unsigned RQ_CNT_W  = $clog2(RES_DEPTH + 1);

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC  = 3'd1;
  localparam logic [2:0] ST_ZERO_WIDTH = 3'd2;
  localparam logic [2:0] ST_ZERO_HEIGHT = 3'd3;
  localparam logic [2:0] ST_BAD_MAXVAL = 3'd4;
  localparam logic [2:0] ST_SIZE       = 3'd5;

  // characters
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_5     = 8'h35;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } pnm_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_byte;
    logic        is_color;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  status;
    logic        last_of_run;
  } pnm_out_t;

  // results of one parsed word, oldest in res[0]
  typedef struct packed {
    logic [1:0]          cnt;
    pnm_out_t [1:0]      res;
  } pnm_push_t;

endpackage

`default_nettype wire

[rtl/core/pnm_parse.sv]
`default_nettype none

module pnm_parse #(
  parameter int unsigned DIM_BITS = pnm_pkg::DIM_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  pnm_pkg::pnm_in_t    in_i,
  output pnm_pkg::pnm_push_t  push_o
);
  import pnm_pkg::*;

  localparam int unsigned ACC_W   = DIM_BITS + 1;
  localparam int unsigned ACC10_W = ACC_W + 4;
  localparam int unsigned PROD_W  = 2 * DIM_BITS;
  localparam int unsigned CNT_W   = 2 * DIM_BITS + 2;
  localparam logic [ACC_W-1:0]    ACC_MAX = '1;
  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;
  localparam logic [CNT_W-1:0]    CNT_MAX = '1;

  typedef enum logic [2:0] {
    PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_PAYLOAD, PH_HALT
  } phase_e;

  typedef enum logic [1:0] {
    NM_SKIP, NM_POS, NM_NEG, NM_STOP
  } num_mode_e;

  phase_e              phase_q, phase_d;
  num_mode_e           mode_q, mode_d, mode_tc;
  logic [1:0]          line_pos_q, line_pos_d;
  logic                magic_ok_q, magic_ok_d;
  logic                color_q, color_d;
  logic [ACC_W-1:0]    field_q, field_d, field_tc;
  logic [DIM_BITS-1:0] width_q, width_d, height_q, height_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [PROD_W-1:0]   prod_q;
  logic [CNT_W-1:0]    expect_q;

  logic [7:0]          b;
  logic                eof;
  logic                digit, blank;
  logic [3:0]          dval;
  logic [ACC10_W-1:0]  acc_ext, acc10;
  logic [ACC_W-1:0]    acc_sat;
  logic [DIM_BITS-1:0] dim_c;
  pnm_push_t           push;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [ACC_W-1:0] v);
    clamp_dim = v[DIM_BITS] ? DIM_MAX : v[DIM_BITS-1:0];
  endfunction

  function automatic logic [15:0] to_out(input logic [DIM_BITS-1:0] v);
    logic [DIM_BITS+15:0] ext;
    ext    = {16'b0, v};
    to_out = ext[15:0];
  endfunction

  function automatic pnm_out_t make_res(input logic [1:0] kind, input logic [7:0] data,
                                        input logic col, input logic [DIM_BITS-1:0] w,
                                        input logic [DIM_BITS-1:0] h, input logic [2:0] st);
    pnm_out_t r;
    r.out_kind     = kind;
    r.out_byte     = data;
    r.is_color     = col;
    r.image_width  = to_out(w);
    r.image_height = to_out(h);
    r.status       = st;
    r.last_of_run  = 1'b0;
    make_res = r;
  endfunction

  assign b   = in_i.in_byte;
  assign eof = in_i.end_of_file;

  // atoi-style digit accumulation, one character per word
  always_comb begin
    digit   = (b >= CH_0) && (b <= CH_9);
    dval    = digit ? 4'(b - CH_0) : 4'd0;
    blank   = (b == CH_SP) || (b == CH_TAB) || (b == CH_NL) ||
              (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    acc_ext = ACC10_W'(field_q);
    acc10   = (acc_ext << 3) + (acc_ext << 1) + ACC10_W'(dval);
    acc_sat = (acc10 > ACC10_W'(ACC_MAX)) ? ACC_MAX : acc10[ACC_W-1:0];
    mode_tc  = mode_q;
    field_tc = field_q;
    unique case (mode_q)
      NM_SKIP: begin
        if (!blank) begin
          if (b == CH_PLUS) begin
            mode_tc = NM_POS;
          end else if (b == CH_MINUS) begin
            mode_tc = NM_NEG;
          end else if (digit) begin
            field_tc = ACC_W'(dval);
            mode_tc  = NM_POS;
          end else begin
            mode_tc = NM_STOP;
          end
        end
      end
      NM_POS: begin
        if (!digit) mode_tc = NM_STOP;
        else        field_tc = acc_sat;
      end
      NM_NEG: begin
        if (!digit) mode_tc = NM_STOP;
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    mode_d     = mode_q;
    line_pos_d = line_pos_q;
    magic_ok_d = magic_ok_q;
    color_d    = color_q;
    field_d    = field_q;
    width_d    = width_q;
    height_d   = height_q;
    count_d    = count_q;
    push       = '0;
    dim_c      = clamp_dim(field_tc);

    unique case (phase_q) inside
      PH_MAGIC: begin
        if (b != CH_NL) begin
          if (line_pos_q == 2'd0) begin
            magic_ok_d = (b == CH_P);
          end else if (line_pos_q == 2'd1) begin
            if (magic_ok_q && ((b == CH_5) || (b == CH_6))) color_d = (b == CH_6);
            else                                           magic_ok_d = 1'b0;
          end
          if (line_pos_q < 2'd2) line_pos_d = line_pos_q + 2'd1;
        end
        if ((b == CH_NL) || eof) begin
          push.cnt = 2'd1;
          phase_d  = PH_HALT;
          if (!(magic_ok_d && (line_pos_d == 2'd2))) begin
            push.res[0] = make_res(KIND_STATUS, 8'd0, color_d, width_d, height_d,
                                   ST_BAD_MAGIC);
          end else if (eof) begin
            // later fields are empty: width fails
            push.res[0] = make_res(KIND_STATUS, 8'd0, color_d, width_d, height_d,
                                   ST_ZERO_WIDTH);
          end else begin
            push.cnt = 2'd0;
            phase_d  = PH_WIDTH;
            mode_d   = NM_SKIP;
            field_d  = '0;
          end
        end
      end
      PH_WIDTH, PH_HEIGHT: begin
        if (((phase_q == PH_WIDTH) && (b == CH_SP)) ||
            ((phase_q == PH_HEIGHT) && (b == CH_NL)) || eof) begin
          if (b == ((phase_q == PH_WIDTH) ? CH_SP : CH_NL)) begin
            dim_c = clamp_dim(field_q);
          end
          push.cnt = 2'd1;
          phase_d  = PH_HALT;
          if (dim_c == '0) begin
            push.res[0] = make_res(KIND_STATUS, 8'd0, color_q, width_q, height_q,
                                   (phase_q == PH_WIDTH) ? ST_ZERO_WIDTH : ST_ZERO_HEIGHT);
          end else begin
            if (phase_q == PH_WIDTH) width_d = dim_c;
            else                     height_d = dim_c;
            if (eof) begin
              push.res[0] = make_res(KIND_STATUS, 8'd0, color_q, width_d, height_d,
                                     (phase_q == PH_WIDTH) ? ST_ZERO_HEIGHT : ST_BAD_MAXVAL);
            end else begin
              push.cnt = 2'd0;
              phase_d  = (phase_q == PH_WIDTH) ? PH_HEIGHT : PH_MAXVAL;
              mode_d   = NM_SKIP;
              field_d  = '0;
            end
          end
        end else begin
          mode_d  = mode_tc;
          field_d = field_tc;
        end
      end
      PH_MAXVAL: begin
        if ((b == CH_NL) || eof) begin
          if (b != CH_NL) field_d = field_tc;
          push.cnt = 2'd1;
          if (field_d != ACC_W'(MAXVAL_OK)) begin
            phase_d     = PH_HALT;
            push.res[0] = make_res(KIND_STATUS, 8'd0, color_q, width_q, height_q,
                                   ST_BAD_MAXVAL);
          end else begin
            phase_d     = PH_PAYLOAD;
            count_d     = '0;
            mode_d      = NM_SKIP;
            field_d     = '0;
            push.res[0] = make_res(KIND_HEADER, 8'd0, color_q, width_q, height_q, ST_OK);
            if (eof) begin
              // no payload at all against a nonzero expected size
              push.cnt    = 2'd2;
              push.res[1] = make_res(KIND_STATUS, 8'd0, color_q, width_q, height_q,
                                     ST_SIZE);
            end
          end
        end else begin
          mode_d  = mode_tc;
          field_d = field_tc;
        end
      end
      PH_PAYLOAD: begin
        push.cnt    = 2'd1;
        push.res[0] = make_res(KIND_PAYLOAD, b, color_q, width_q, height_q, ST_OK);
        if (count_q != CNT_MAX) count_d = count_q + CNT_W'(1);
        if (eof) begin
          push.cnt    = 2'd2;
          push.res[1] = make_res(KIND_STATUS, 8'd0, color_q, width_q, height_q,
                                 (count_d == expect_q) ? ST_OK : ST_SIZE);
        end
      end
      default: ;
    endcase

    if (push.cnt == 2'd2)      push.res[1].last_of_run = 1'b1;
    else if (push.cnt == 2'd1) push.res[0].last_of_run = 1'b1;

    // end of file: start over for the next file
    if (eof) begin
      phase_d    = PH_MAGIC;
      mode_d     = NM_SKIP;
      line_pos_d = 2'd0;
      magic_ok_d = 1'b0;
      color_d    = 1'b0;
      field_d    = '0;
      width_d    = '0;
      height_d   = '0;
      count_d    = '0;
    end

    if (!fire_i) push.cnt = 2'd0;
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC;
      mode_q     <= NM_SKIP;
      line_pos_q <= 2'd0;
      magic_ok_q <= 1'b0;
      color_q    <= 1'b0;
      field_q    <= '0;
      width_q    <= '0;
      height_q   <= '0;
      count_q    <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      mode_q     <= mode_d;
      line_pos_q <= line_pos_d;
      magic_ok_q <= magic_ok_d;
      color_q    <= color_d;
      field_q    <= field_d;
      width_q    <= width_d;
      height_q   <= height_d;
      count_q    <= count_d;
    end
  end

  // expected payload size, registered in prod_q and then in expect_q once the height
  // is taken, long before any payload word can arrive
  always_ff @(posedge clk_i) begin
    prod_q   <= width_q * height_q;
    expect_q <= color_q ? ((CNT_W'(prod_q) << 1) + CNT_W'(prod_q)) : CNT_W'(prod_q);
  end

endmodule

`default_nettype wire

[rtl/core/pnm_res_fifo.sv]
`default_nettype none

module pnm_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pnm_pkg::pnm_push_t  push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pnm_pkg::pnm_out_t   out_data_o
);
  import pnm_pkg::*;

  pnm_out_t            mem_q [RES_DEPTH];
  logic [RQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_nx;
  logic [RQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RQ_CNT_W-1:0] count_q, count_d;
  logic                pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // room for a full two-result word
  assign room_o      = (count_q <= RQ_CNT_W'(RES_DEPTH - 2));

  always_comb begin
    wr_ptr_nx = wr_ptr_q + RQ_PTR_W'(1);
    wr_ptr_d  = wr_ptr_q + RQ_PTR_W'(push_i.cnt);
    rd_ptr_d  = pop ? rd_ptr_q + RQ_PTR_W'(1) : rd_ptr_q;
    count_d   = count_q + RQ_CNT_W'(push_i.cnt) - RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q]  <= push_i.res[0];
    if (push_i.cnt == 2'd2) mem_q[wr_ptr_nx] <= push_i.res[1];
  end

endmodule

`default_nettype wire

[rtl/core/pnm_header_parser.sv]
// Binary netpbm (P5/P6) header parser. Takes the file one byte per word, checks
// the magic line, width, height and maxval, sends one header-info result, then
// forwards every payload byte and closes the file with a status result that
// compares the payload size against width*height*(1 or 3). While the result queue
// has room, a byte is taken every cycle: it sits in the input register, is parsed
// in one step and its results go into a four-entry result queue, so a result
// reaches the output only after both the input register and that queue. The
// input stalls while that queue has fewer than two free entries; the end-of-file
// byte of a file with payload makes two results. Error status ends the parse;
// bytes up to end of file are then dropped without results.
`default_nettype none
`include "assert_macros.svh"

module pnm_header_parser #(
  parameter int unsigned DIM_BITS = pnm_pkg::DIM_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pnm_pkg::pnm_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pnm_pkg::pnm_out_t  out_data_o
);
  import pnm_pkg::*;

  pnm_in_t   in_q;
  logic      in_valid_q;
  logic      room;
  logic      fire;
  pnm_push_t push;

  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // hold the word while stalled
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_data_i;
  end

  pnm_parse #(
    .DIM_BITS (DIM_BITS)
  ) u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .in_i   (in_q),
    .push_o (push)
  );

  pnm_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `ASSERT_CHK(a_push_only_on_fire, (push.cnt != 2'd0) |-> fire)
  `ASSERT_CHK(a_payload_status_ok,
              (out_valid_o && (out_data_o.out_kind == KIND_PAYLOAD))
              |-> (out_data_o.status == ST_OK))
  `ASSERT_CHK(a_status_is_last,
              (out_valid_o && (out_data_o.out_kind == KIND_STATUS))
              |-> out_data_o.last_of_run)

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps

import pnm_pkg::*;

localparam int unsigned DIM_W = DIM_BITS_DEF;
localparam logic [DIM_W:0] ACC_LIMIT = '1;
localparam logic [DIM_W-1:0] DIM_LIMIT = '1;

class pnm_result_board;
  typedef enum logic [2:0] {
    STEP_MAGIC, STEP_WIDTH, STEP_HEIGHT, STEP_MAXVAL, STEP_PAYLOAD, STEP_HALT
  } hdr_step_e;
  typedef enum logic [1:0] {NUM_SKIP, NUM_POS, NUM_NEG, NUM_STOP} num_mode_e;

  hdr_step_e         step;
  logic [1:0]        magic_pos;
  bit                magic_good;
  num_mode_e         mode;
  logic [DIM_W:0]    acc;
  bit                colour;
  logic [DIM_W-1:0]  img_w;
  logic [DIM_W-1:0]  img_h;
  logic [2*DIM_W+1:0] size_due;
  logic [2*DIM_W+1:0] size_seen;
  pnm_out_t          results_due[$];
  pnm_out_t          fresh[$];
  int unsigned       mismatches;

  function new();
    mismatches = 0;
    clear();
  endfunction

  function void clear();
    step = STEP_MAGIC;
    magic_pos = '0;
    magic_good = 1'b0;
    colour = 1'b0;
    img_w = '0;
    img_h = '0;
    size_due = '0;
    size_seen = '0;
    mode = NUM_SKIP;
    acc = '0;
  endfunction

  function int unsigned pending();
    return results_due.size();
  endfunction

  function void push(logic [1:0] kind, logic [7:0] b, logic [2:0] st);
    pnm_out_t r;
    r.out_kind = kind;
    r.out_byte = b;
    r.is_color = colour;
    r.image_width = img_w;
    r.image_height = img_h;
    r.status = st;
    r.last_of_run = 1'b0;
    fresh.push_back(r);
  endfunction

  function bit blank_char(logic [7:0] b);
    return b inside {CH_SP, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR};
  endfunction

  // atoi-style digit accumulation, saturating one bit above the dimension width
  function void feed_number(logic [7:0] b);
    bit is_digit;
    logic [3:0] d;
    is_digit = (b >= CH_0) && (b <= CH_9);
    d = is_digit ? 4'(b - CH_0) : 4'd0;
    case (mode)
      NUM_SKIP: begin
        if (blank_char(b)) ;
        else if (b == CH_PLUS) mode = NUM_POS;
        else if (b == CH_MINUS) mode = NUM_NEG;
        else if (is_digit) begin
          acc = d;
          mode = NUM_POS;
        end else mode = NUM_STOP;
      end
      NUM_POS: begin
        if (!is_digit) mode = NUM_STOP;
        else if (32'(acc) > (32'(ACC_LIMIT) - d) / 10) acc = ACC_LIMIT;
        else acc = acc * 10 + d;
      end
      NUM_NEG: begin
        if (!is_digit) mode = NUM_STOP;
      end
      default: ;
    endcase
  endfunction

  function logic [DIM_W-1:0] to_dim(logic [DIM_W:0] v);
    return (v > DIM_LIMIT) ? DIM_LIMIT : v[DIM_W-1:0];
  endfunction

  function logic [2:0] close_field();
    case (step)
      STEP_MAGIC: begin
        if (!(magic_good && magic_pos == 2'd2)) return ST_BAD_MAGIC;
        step = STEP_WIDTH;
      end
      STEP_WIDTH: begin
        if (to_dim(acc) == 0) return ST_ZERO_WIDTH;
        img_w = to_dim(acc);
        step = STEP_HEIGHT;
      end
      STEP_HEIGHT: begin
        if (to_dim(acc) == 0) return ST_ZERO_HEIGHT;
        img_h = to_dim(acc);
        step = STEP_MAXVAL;
      end
      default: begin
        if (acc != MAXVAL_OK) return ST_BAD_MAXVAL;
        size_due = (2*DIM_W+2)'(img_w) * (2*DIM_W+2)'(img_h) *
                   (colour ? (2*DIM_W+2)'(3) : (2*DIM_W+2)'(1));
        size_seen = '0;
        push(KIND_HEADER, 8'h00, ST_OK);
        step = STEP_PAYLOAD;
      end
    endcase
    mode = NUM_SKIP;
    acc = '0;
    return ST_OK;
  endfunction

  function void note_word(pnm_in_t w);
    logic [7:0] b;
    bit eof;
    bit ended;
    logic [2:0] st;
    pnm_out_t r;
    b = w.in_byte;
    eof = w.end_of_file;
    ended = 1'b0;
    fresh.delete();
    case (step) inside
      STEP_MAGIC: begin
        if (b == CH_NL) ended = 1'b1;
        else begin
          if (magic_pos == 2'd0) magic_good = (b == CH_P);
          else if (magic_pos == 2'd1) begin
            if (magic_good && (b == CH_5 || b == CH_6)) colour = (b == CH_6);
            else magic_good = 1'b0;
          end
          if (magic_pos < 2'd2) magic_pos++;
        end
      end
      STEP_WIDTH: begin
        if (b == CH_SP) ended = 1'b1;
        else feed_number(b);
      end
      STEP_HEIGHT, STEP_MAXVAL: begin
        if (b == CH_NL) ended = 1'b1;
        else feed_number(b);
      end
      STEP_PAYLOAD: begin
        push(KIND_PAYLOAD, b, ST_OK);
        size_seen++;
      end
      default: ;
    endcase

    // on end of file every remaining header field closes as empty
    if (ended || eof) begin
      while (step <= STEP_MAXVAL) begin
        st = close_field();
        if (st != ST_OK) begin
          push(KIND_STATUS, 8'h00, st);
          step = STEP_HALT;
          break;
        end
        if (!eof) break;
      end
      if (eof && step == STEP_PAYLOAD)
        push(KIND_STATUS, 8'h00, (size_seen == size_due) ? ST_OK : ST_SIZE);
    end

    if (fresh.size() > 0) begin
      r = fresh.pop_back();
      r.last_of_run = 1'b1;
      fresh.push_back(r);
    end
    foreach (fresh[i]) results_due.push_back(fresh[i]);
    if (eof) clear();
  endfunction

  function void report_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(pnm_out_t got);
    pnm_out_t want;
    if (results_due.size() == 0) begin
      $error("result with none pending: kind %0d", got.out_kind);
      mismatches++;
      return;
    end
    want = results_due.pop_front();
    report_field("out_kind", want.out_kind, got.out_kind);
    report_field("out_byte", want.out_byte, got.out_byte);
    report_field("is_color", want.is_color, got.is_color);
    report_field("image_width", want.image_width, got.image_width);
    report_field("image_height", want.image_height, got.image_height);
    report_field("status", want.status, got.status);
    report_field("last_of_run", want.last_of_run, got.last_of_run);
  endfunction
endclass

module testbench;
  localparam int unsigned WORDS = 1700;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pnm_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pnm_out_t out_data;

  pnm_result_board sb = new();

  logic [7:0]  file_bytes[$];
  bit          steady;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycles = 0;

  pnm_header_parser uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
      results_seen <= results_seen + 1;
    end
  end

  // receiver: random stall bursts, plus a long hold now and then to back up the input
  initial begin
    int unsigned r;
    int unsigned span;
    int unsigned next_hold;
    logic hold;
    out_stall = 1'b0;
    next_hold = 150;
    @(posedge rst_n);
    forever begin
      r = $urandom_range(0, 99);
      if (results_seen >= next_hold) begin
        hold = 1'b1;
        span = 400;
        next_hold = next_hold + 700;
      end else if (r < 45) begin
        hold = 1'b0;
        span = $urandom_range(1, 8);
      end else if (r < 55) begin
        hold = 1'b0;
        span = $urandom_range(30, 100);
      end else if (r < 82) begin
        hold = 1'b1;
        span = $urandom_range(1, 3);
      end else if (r < 96) begin
        hold = 1'b1;
        span = $urandom_range(4, 12);
      end else begin
        hold = 1'b1;
        span = $urandom_range(20, 60);
      end
      repeat (span) begin
        @(negedge clk);
        out_stall <= hold;
      end
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eof);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{in_byte: b, end_of_file: eof};
    do @(posedge clk); while (in_stall);
    sb.note_word(in_data);
    words_sent++;
  endtask

  task automatic send_file();
    steady = ($urandom_range(0, 3) == 0);
    foreach (file_bytes[i]) send_word(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) file_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_blank(bit in_width);
    case ($urandom_range(0, 4))
      0: return CH_TAB;
      1: return CH_VT;
      2: return CH_FF;
      3: return CH_CR;
      default: return in_width ? CH_NL : CH_SP;
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0: return CH_P;
      1: return 8'($urandom_range(CH_0, CH_9));
      2: return CH_NL;
      3: return CH_SP;
      4: return $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
      default: return 8'($urandom);
    endcase
  endfunction

  // width or height text with its terminator; returns the value the payload size uses
  function automatic int unsigned add_dim_field(bit in_width);
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 99);
    v = (r < 4) ? 0 : $urandom_range(1, 5);
    if ($urandom_range(0, 4) == 0) file_bytes.push_back(pick_blank(in_width));
    if ($urandom_range(0, 6) == 0) file_bytes.push_back(CH_PLUS);
    if ($urandom_range(0, 9) == 0) file_bytes.push_back(CH_0);
    if (r >= 96) begin
      add_text($sformatf("%0d", $urandom_range(65536, 9999999)));
      v = 0;
    end else begin
      add_text($sformatf("%0d", v));
    end
    if ($urandom_range(0, 19) == 0) add_text("x");
    file_bytes.push_back(in_width ? CH_SP : CH_NL);
    return v;
  endfunction

  task automatic build_random_file();
    int unsigned r;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned cut;
    bit col;
    logic [7:0] b;
    file_bytes.delete();
    r = $urandom_range(0, 99);
    if (r >= 85) begin
      repeat ($urandom_range(1, 12)) file_bytes.push_back(noise_byte());
      return;
    end
    col = $urandom_range(0, 1);
    add_text(col ? "P6" : "P5");
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        file_bytes.push_back((b == CH_NL) ? CH_SP : b);
      end
    end
    file_bytes.push_back(CH_NL);
    w = add_dim_field(1'b1);
    h = add_dim_field(1'b0);
    case ($urandom_range(0, 19))
      0: add_text("+255");
      1: add_text("0255");
      2: add_text($sformatf("%0d", $urandom_range(0, 300)));
      3: add_text("-255");
      4: add_text("99999999");
      5: add_text("\t255");
      default: add_text("255");
    endcase
    file_bytes.push_back(CH_NL);
    n = w * h * (col ? 3 : 1);
    r = $urandom_range(0, 99);
    if (r < 8) n = n + 1;
    else if (r < 16 && n > 0) n = n - 1;
    repeat (n) file_bytes.push_back(8'($urandom));
    // break off a share of the files that start with a magic line at a random point
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endtask

  task automatic send_text(string s);
    file_bytes.delete();
    add_text(s);
    send_file();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // magic line cut short by end of file
    send_text("P");
    // leading minus in width reads as zero
    send_text("P6\n-");
    // saturated width; header ends on the last byte, so no payload
    send_text("P6\n99999 1\n255\n");
    // bad magic, then drop bytes until end of file
    send_text("Q\nab");

    while (words_sent < WORDS) begin
      build_random_file();
      send_file();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/pnm_pkg.sv
rtl/core/pnm_parse.sv
rtl/core/pnm_res_fifo.sv
rtl/core/pnm_header_parser.sv
sim/testbench.sv
